// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the core datapath module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define HCB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define HCB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

// ===== rtl/core/hcb_pkg.sv =====
// Shared codes, datapath operations and status type of the Huffman core.
package hcb_pkg;

  localparam int unsigned SYM_W  = 8;
  localparam int unsigned CODE_W = 63;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned FREQ_W = 16;
  localparam int unsigned OP_W   = 5;

  localparam logic [1:0] CMD_TEXT   = 2'd0;
  localparam logic [1:0] CMD_BUILD  = 2'd1;
  localparam logic [1:0] CMD_DECODE = 2'd2;

  localparam logic [1:0] KIND_CODE = 2'd0;
  localparam logic [1:0] KIND_SYM  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [OP_W-1:0] OP_NONE        = 5'd0;
  localparam logic [OP_W-1:0] OP_TEXT_START  = 5'd1;
  localparam logic [OP_W-1:0] OP_TEXT_INC    = 5'd2;
  localparam logic [OP_W-1:0] OP_BUILD_FAIL  = 5'd3;
  localparam logic [OP_W-1:0] OP_BUILD_START = 5'd4;
  localparam logic [OP_W-1:0] OP_LEAF_RD     = 5'd5;
  localparam logic [OP_W-1:0] OP_LEAF_SKIP   = 5'd6;
  localparam logic [OP_W-1:0] OP_LEAF_WR     = 5'd7;
  localparam logic [OP_W-1:0] OP_PASS_START  = 5'd8;
  localparam logic [OP_W-1:0] OP_NODE_RD_I   = 5'd9;
  localparam logic [OP_W-1:0] OP_PASS_CMP    = 5'd10;
  localparam logic [OP_W-1:0] OP_TAKE_A      = 5'd11;
  localparam logic [OP_W-1:0] OP_MERGE_WR    = 5'd12;
  localparam logic [OP_W-1:0] OP_FINAL       = 5'd13;
  localparam logic [OP_W-1:0] OP_POP         = 5'd14;
  localparam logic [OP_W-1:0] OP_STK_NODE    = 5'd15;
  localparam logic [OP_W-1:0] OP_PUSH_R      = 5'd16;
  localparam logic [OP_W-1:0] OP_PUSH_L      = 5'd17;
  localparam logic [OP_W-1:0] OP_LEAF_CNT    = 5'd18;
  localparam logic [OP_W-1:0] OP_EMIT_CODE   = 5'd19;
  localparam logic [OP_W-1:0] OP_DEC_START   = 5'd20;
  localparam logic [OP_W-1:0] OP_DEC_CHILD   = 5'd21;
  localparam logic [OP_W-1:0] OP_DEC_DESCEND = 5'd22;
  localparam logic [OP_W-1:0] OP_DEC_HIT     = 5'd23;
  localparam logic [OP_W-1:0] OP_EMIT_SYM    = 5'd24;
  localparam logic [OP_W-1:0] OP_EMIT_ERR    = 5'd25;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } hcb_cmd_t;

  typedef struct packed {
    logic tree_built;
    logic root_leaf;
    logic distinct_bad;
    logic scan_end;
    logic leaf_valid;
    logic one_left;
    logic pass_end;
    logic node_leaf;
    logic stack_empty;
    logic out_free;
  } hcb_status_t;

endpackage

// ===== rtl/core/hcb_ctrl.sv =====
// Sequencer that steps the datapath through count, build, emit and decode.
module hcb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_cmd_i,
  output logic                in_stall_o,
  input  hcb_pkg::hcb_status_t status_i,
  output hcb_pkg::hcb_cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_TXT    = 5'd1;
  localparam logic [4:0] S_ERR    = 5'd2;
  localparam logic [4:0] S_LSCAN  = 5'd3;
  localparam logic [4:0] S_LWR    = 5'd4;
  localparam logic [4:0] S_MCHK   = 5'd5;
  localparam logic [4:0] S_ARD    = 5'd6;
  localparam logic [4:0] S_ACMP   = 5'd7;
  localparam logic [4:0] S_ATAKE  = 5'd8;
  localparam logic [4:0] S_BRD    = 5'd9;
  localparam logic [4:0] S_BCMP   = 5'd10;
  localparam logic [4:0] S_MWR    = 5'd11;
  localparam logic [4:0] S_POP    = 5'd12;
  localparam logic [4:0] S_SNODE  = 5'd13;
  localparam logic [4:0] S_NODE   = 5'd14;
  localparam logic [4:0] S_PUSHL  = 5'd15;
  localparam logic [4:0] S_ECODE  = 5'd16;
  localparam logic [4:0] S_DCHILD = 5'd17;
  localparam logic [4:0] S_DN     = 5'd18;
  localparam logic [4:0] S_DOUT   = 5'd19;

  logic [4:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Pick the datapath operation and the next state
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = hcb_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd_i)
            hcb_pkg::CMD_TEXT: begin
              cmd_o.op = hcb_pkg::OP_TEXT_START;
              state_d  = S_TXT;
            end
            hcb_pkg::CMD_BUILD: begin
              if (status_i.distinct_bad) begin
                cmd_o.op = hcb_pkg::OP_BUILD_FAIL;
                state_d  = S_ERR;
              end else begin
                cmd_o.op = hcb_pkg::OP_BUILD_START;
                state_d  = S_LSCAN;
              end
            end
            hcb_pkg::CMD_DECODE: begin
              if (!status_i.tree_built) begin
                state_d = S_ERR;
              end else begin
                cmd_o.op = hcb_pkg::OP_DEC_START;
                state_d  = status_i.root_leaf ? S_DN : S_DCHILD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_TXT: begin
        cmd_o.op = hcb_pkg::OP_TEXT_INC;
        state_d  = S_IDLE;
      end
      S_ERR: begin
        if (status_i.out_free) begin
          cmd_o.op = hcb_pkg::OP_EMIT_ERR;
          state_d  = S_IDLE;
        end
      end
      S_LSCAN: begin
        if (status_i.scan_end) begin
          state_d = S_MCHK;
        end else if (status_i.leaf_valid) begin
          cmd_o.op = hcb_pkg::OP_LEAF_RD;
          state_d  = S_LWR;
        end else begin
          cmd_o.op = hcb_pkg::OP_LEAF_SKIP;
        end
      end
      S_LWR: begin
        cmd_o.op = hcb_pkg::OP_LEAF_WR;
        state_d  = S_LSCAN;
      end
      S_MCHK: begin
        if (status_i.one_left) begin
          cmd_o.op = hcb_pkg::OP_FINAL;
          state_d  = S_POP;
        end else begin
          cmd_o.op = hcb_pkg::OP_PASS_START;
          state_d  = S_ARD;
        end
      end
      S_ARD: begin
        cmd_o.op = hcb_pkg::OP_NODE_RD_I;
        state_d  = S_ACMP;
      end
      S_ACMP: begin
        cmd_o.op = hcb_pkg::OP_PASS_CMP;
        state_d  = status_i.pass_end ? S_ATAKE : S_ARD;
      end
      S_ATAKE: begin
        cmd_o.op = hcb_pkg::OP_TAKE_A;
        state_d  = S_BRD;
      end
      S_BRD: begin
        cmd_o.op = hcb_pkg::OP_NODE_RD_I;
        state_d  = S_BCMP;
      end
      S_BCMP: begin
        cmd_o.op = hcb_pkg::OP_PASS_CMP;
        state_d  = status_i.pass_end ? S_MWR : S_BRD;
      end
      S_MWR: begin
        cmd_o.op = hcb_pkg::OP_MERGE_WR;
        state_d  = S_MCHK;
      end
      S_POP: begin
        if (status_i.stack_empty) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = hcb_pkg::OP_POP;
          state_d  = S_SNODE;
        end
      end
      S_SNODE: begin
        cmd_o.op = hcb_pkg::OP_STK_NODE;
        state_d  = S_NODE;
      end
      S_NODE: begin
        if (status_i.node_leaf) begin
          cmd_o.op = hcb_pkg::OP_LEAF_CNT;
          state_d  = S_ECODE;
        end else begin
          cmd_o.op = hcb_pkg::OP_PUSH_R;
          state_d  = S_PUSHL;
        end
      end
      S_PUSHL: begin
        cmd_o.op = hcb_pkg::OP_PUSH_L;
        state_d  = S_POP;
      end
      S_ECODE: begin
        if (status_i.out_free) begin
          cmd_o.op = hcb_pkg::OP_EMIT_CODE;
          state_d  = status_i.stack_empty ? S_IDLE : S_POP;
        end
      end
      S_DCHILD: begin
        cmd_o.op = hcb_pkg::OP_DEC_CHILD;
        state_d  = S_DN;
      end
      S_DN: begin
        if (status_i.node_leaf) begin
          cmd_o.op = hcb_pkg::OP_DEC_HIT;
          state_d  = S_DOUT;
        end else begin
          cmd_o.op = hcb_pkg::OP_DEC_DESCEND;
          state_d  = S_IDLE;
        end
      end
      S_DOUT: begin
        if (status_i.out_free) begin
          cmd_o.op = hcb_pkg::OP_EMIT_SYM;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/hcb_datapath.sv =====
// Count store, node store, traversal stack and output register of the Huffman core.
`include "assert_macros.svh"
module hcb_datapath #(
  parameter int unsigned MAX_SYMBOLS = 64,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hcb_pkg::hcb_cmd_t                 cmd_i,
  input  logic [hcb_pkg::SYM_W-1:0]         in_symbol_i,
  input  logic                              in_code_bit_i,
  input  logic                              out_stall_i,
  output hcb_pkg::hcb_status_t              status_o,
  output logic                              out_valid_o,
  output logic [1:0]                        out_kind_o,
  output logic [hcb_pkg::SYM_W-1:0]         out_symbol_o,
  output logic [hcb_pkg::CODE_W-1:0]        out_code_value_o,
  output logic [hcb_pkg::LEN_W-1:0]         out_code_length_o,
  output logic [hcb_pkg::FREQ_W-1:0]        out_frequency_o,
  output logic                              out_last_o
);

  localparam int unsigned NODES = 2 * MAX_SYMBOLS - 1;
  localparam int unsigned NIW   = $clog2(NODES);
  localparam int unsigned CW    = NIW + 1;
  localparam int unsigned WW    = COUNT_BITS + $clog2(MAX_SYMBOLS);
  localparam int unsigned LCW   = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned SIW   = $clog2(MAX_SYMBOLS);
  localparam int unsigned SPW   = SIW + 1;
  localparam int unsigned NSYM  = 1 << hcb_pkg::SYM_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [hcb_pkg::OP_W-1:0] op;
  assign op = cmd_i.op;

  // Count store with per-symbol valid bits
  logic [COUNT_BITS-1:0]      cnt_mem [NSYM];
  logic [NSYM-1:0]            cnt_vld_q;
  logic [COUNT_BITS-1:0]      cnt_rdata_q;
  logic                       cnt_rvld_q;
  logic                       cnt_re;
  logic [hcb_pkg::SYM_W-1:0]  cnt_raddr;
  logic [COUNT_BITS-1:0]      cnt_val, cnt_next;
  logic                       text_clear;

  // Node store
  logic [WW-1:0]             nw_mem   [NODES];
  logic [hcb_pkg::SYM_W-1:0] ns_mem   [NODES];
  logic [NIW-1:0]            nl_mem   [NODES];
  logic [NIW-1:0]            nr_mem   [NODES];
  logic                      nleaf_mem[NODES];
  logic [WW-1:0]             nd_w_q;
  logic [hcb_pkg::SYM_W-1:0] nd_sym_q;
  logic [NIW-1:0]            nd_l_q, nd_r_q;
  logic                      nd_leaf_q;
  logic                      n_re, n_we;
  logic [NIW-1:0]            n_raddr;
  logic [WW-1:0]             nw_wdata;
  logic [hcb_pkg::SYM_W-1:0] ns_wdata;
  logic [NIW-1:0]            nl_wdata, nr_wdata;
  logic                      a_ge;

  // Traversal stack
  logic [NIW-1:0]             stk_node_mem [MAX_SYMBOLS];
  logic [hcb_pkg::CODE_W-1:0] stk_code_mem [MAX_SYMBOLS];
  logic [hcb_pkg::LEN_W-1:0]  stk_len_mem  [MAX_SYMBOLS];
  logic [NIW-1:0]             stk_node_q;
  logic [hcb_pkg::CODE_W-1:0] stk_code_q;
  logic [hcb_pkg::LEN_W-1:0]  stk_len_q;
  logic                       stk_we;
  logic [SIW-1:0]             stk_waddr;
  logic [NIW-1:0]             stk_wnode;
  logic [hcb_pkg::CODE_W-1:0] stk_wcode;
  logic [hcb_pkg::LEN_W-1:0]  stk_wlen;
  logic [SPW-1:0]             sp_q, sp_m1;

  // Build and decode state
  logic [hcb_pkg::SYM_W:0]    distinct_q;
  logic                       tree_built_q, root_leaf_q;
  logic [NIW-1:0]             root_q, dec_q;
  logic [hcb_pkg::SYM_W:0]    s_q;
  logic [CW-1:0]              used_q, i_q;
  logic                       found_q;
  logic [NODES-1:0]           live_q;
  logic [LCW-1:0]             live_cnt_q;
  logic                       out_valid_q;
  logic [hcb_pkg::SYM_W-1:0]  sym_q;
  logic                       code_bit_q;
  logic [WW-1:0]              best_w_q, a_w_q;
  logic [hcb_pkg::SYM_W-1:0]  best_sym_q;
  logic [NIW-1:0]             best_idx_q, a_idx_q, nsel_q;
  logic [hcb_pkg::CODE_W-1:0] cur_code_q;
  logic [hcb_pkg::LEN_W-1:0]  cur_len_q;
  logic                       better;
  logic                       out_free;

  assign cnt_val    = cnt_rvld_q ? cnt_rdata_q : '0;
  assign cnt_next   = (cnt_val == COUNT_MAX) ? cnt_val : cnt_val + COUNT_BITS'(1);
  assign text_clear = (op == hcb_pkg::OP_TEXT_START) && tree_built_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sp_m1      = SPW'(sp_q - SPW'(1));

  // Select the count read address
  always_comb begin
    cnt_re    = 1'b0;
    cnt_raddr = nd_sym_q;
    case (op)
      hcb_pkg::OP_TEXT_START: begin
        cnt_re    = 1'b1;
        cnt_raddr = in_symbol_i;
      end
      hcb_pkg::OP_LEAF_RD: begin
        cnt_re    = 1'b1;
        cnt_raddr = s_q[hcb_pkg::SYM_W-1:0];
      end
      hcb_pkg::OP_LEAF_CNT, hcb_pkg::OP_DEC_HIT: cnt_re = 1'b1;
      default: cnt_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (op == hcb_pkg::OP_TEXT_INC) cnt_mem[sym_q] <= cnt_next;
    if (cnt_re) cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  // Select the node read address and build the node write data
  always_comb begin
    n_re    = 1'b1;
    n_raddr = '0;
    case (op)
      hcb_pkg::OP_NODE_RD_I: n_raddr = i_q[NIW-1:0];
      hcb_pkg::OP_STK_NODE:  n_raddr = stk_node_q;
      hcb_pkg::OP_DEC_START: n_raddr = root_leaf_q ? root_q : dec_q;
      hcb_pkg::OP_DEC_CHILD: n_raddr = code_bit_q ? nd_r_q : nd_l_q;
      default:               n_re    = 1'b0;
    endcase
  end

  assign a_ge     = (a_w_q >= best_w_q);
  assign n_we     = (op == hcb_pkg::OP_LEAF_WR) || (op == hcb_pkg::OP_MERGE_WR);
  assign nw_wdata = (op == hcb_pkg::OP_LEAF_WR) ? WW'(cnt_val) : WW'(a_w_q + best_w_q);
  assign ns_wdata = (op == hcb_pkg::OP_LEAF_WR) ? s_q[hcb_pkg::SYM_W-1:0] : '0;
  assign nl_wdata = a_ge ? best_idx_q : a_idx_q;
  assign nr_wdata = a_ge ? a_idx_q : best_idx_q;

  always_ff @(posedge clk_i) begin
    if (n_we) begin
      nw_mem[used_q[NIW-1:0]]    <= nw_wdata;
      ns_mem[used_q[NIW-1:0]]    <= ns_wdata;
      nl_mem[used_q[NIW-1:0]]    <= nl_wdata;
      nr_mem[used_q[NIW-1:0]]    <= nr_wdata;
      nleaf_mem[used_q[NIW-1:0]] <= (op == hcb_pkg::OP_LEAF_WR);
    end
    if (n_re) begin
      nd_w_q    <= nw_mem[n_raddr];
      nd_sym_q  <= ns_mem[n_raddr];
      nd_l_q    <= nl_mem[n_raddr];
      nd_r_q    <= nr_mem[n_raddr];
      nd_leaf_q <= nleaf_mem[n_raddr];
    end
  end

  // Build the stack write: the root first, then right and left children
  always_comb begin
    stk_we    = 1'b1;
    stk_waddr = sp_q[SIW-1:0];
    stk_wnode = nd_r_q;
    stk_wcode = {cur_code_q[hcb_pkg::CODE_W-2:0], 1'b1};
    stk_wlen  = cur_len_q + hcb_pkg::LEN_W'(1);
    case (op)
      hcb_pkg::OP_FINAL: begin
        stk_waddr = '0;
        stk_wnode = root_q;
        stk_wcode = '0;
        stk_wlen  = '0;
      end
      hcb_pkg::OP_PUSH_R: stk_wnode = nd_r_q;
      hcb_pkg::OP_PUSH_L: begin
        stk_wnode = nd_l_q;
        stk_wcode = {cur_code_q[hcb_pkg::CODE_W-2:0], 1'b0};
      end
      default: stk_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_node_mem[stk_waddr] <= stk_wnode;
      stk_code_mem[stk_waddr] <= stk_wcode;
      stk_len_mem[stk_waddr]  <= stk_wlen;
    end
    if (op == hcb_pkg::OP_POP) begin
      stk_node_q <= stk_node_mem[sp_m1[SIW-1:0]];
      stk_code_q <= stk_code_mem[sp_m1[SIW-1:0]];
      stk_len_q  <= stk_len_mem[sp_m1[SIW-1:0]];
    end
  end

  // Rank the candidate against the best live node so far
  assign better = live_q[i_q[NIW-1:0]] &&
                  (!found_q || (nd_w_q < best_w_q) ||
                   ((nd_w_q == best_w_q) && (nd_sym_q < best_sym_q)));

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q    <= '0;
      cnt_rvld_q   <= 1'b0;
      distinct_q   <= '0;
      tree_built_q <= 1'b0;
      root_leaf_q  <= 1'b0;
      root_q       <= '0;
      dec_q        <= '0;
      s_q          <= '0;
      used_q       <= '0;
      i_q          <= '0;
      found_q      <= 1'b0;
      live_q       <= '0;
      live_cnt_q   <= '0;
      sp_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cnt_re) begin
        cnt_rvld_q <= cnt_vld_q[cnt_raddr] && !text_clear;
      end
      if (op == hcb_pkg::OP_EMIT_CODE || op == hcb_pkg::OP_EMIT_SYM ||
          op == hcb_pkg::OP_EMIT_ERR) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (op)
        hcb_pkg::OP_TEXT_START: begin
          if (tree_built_q) begin
            cnt_vld_q    <= '0;
            distinct_q   <= '0;
            tree_built_q <= 1'b0;
            root_q       <= '0;
            dec_q        <= '0;
          end
        end
        hcb_pkg::OP_TEXT_INC: begin
          cnt_vld_q[sym_q] <= 1'b1;
          if (!cnt_rvld_q) distinct_q <= distinct_q + (hcb_pkg::SYM_W + 1)'(1);
        end
        hcb_pkg::OP_BUILD_FAIL: tree_built_q <= 1'b0;
        hcb_pkg::OP_BUILD_START: begin
          tree_built_q <= 1'b0;
          s_q          <= '0;
          used_q       <= '0;
          live_q       <= '0;
          live_cnt_q   <= LCW'(distinct_q);
          root_q       <= '0;
        end
        hcb_pkg::OP_LEAF_SKIP: s_q <= s_q + (hcb_pkg::SYM_W + 1)'(1);
        hcb_pkg::OP_LEAF_WR: begin
          live_q[used_q[NIW-1:0]] <= 1'b1;
          used_q                  <= used_q + CW'(1);
          s_q                     <= s_q + (hcb_pkg::SYM_W + 1)'(1);
        end
        hcb_pkg::OP_PASS_START: begin
          i_q     <= '0;
          found_q <= 1'b0;
        end
        hcb_pkg::OP_PASS_CMP: begin
          if (better) found_q <= 1'b1;
          i_q <= i_q + CW'(1);
        end
        hcb_pkg::OP_TAKE_A: begin
          live_q[best_idx_q] <= 1'b0;
          i_q                <= '0;
          found_q            <= 1'b0;
        end
        hcb_pkg::OP_MERGE_WR: begin
          live_q[best_idx_q]      <= 1'b0;
          live_q[used_q[NIW-1:0]] <= 1'b1;
          used_q                  <= used_q + CW'(1);
          live_cnt_q              <= live_cnt_q - LCW'(1);
          root_q                  <= used_q[NIW-1:0];
        end
        hcb_pkg::OP_FINAL: begin
          tree_built_q <= 1'b1;
          root_leaf_q  <= (distinct_q == (hcb_pkg::SYM_W + 1)'(1));
          dec_q        <= root_q;
          sp_q         <= SPW'(1);
        end
        hcb_pkg::OP_POP: sp_q <= sp_m1;
        hcb_pkg::OP_PUSH_R, hcb_pkg::OP_PUSH_L: sp_q <= sp_q + SPW'(1);
        hcb_pkg::OP_DEC_DESCEND: dec_q <= nsel_q;
        hcb_pkg::OP_DEC_HIT: dec_q <= root_q;
        default: sp_q <= sp_q;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (op)
      hcb_pkg::OP_TEXT_START: sym_q <= in_symbol_i;
      hcb_pkg::OP_DEC_START:  code_bit_q <= in_code_bit_i;
      hcb_pkg::OP_DEC_CHILD:  nsel_q <= code_bit_q ? nd_r_q : nd_l_q;
      hcb_pkg::OP_PASS_CMP: begin
        if (better) begin
          best_w_q   <= nd_w_q;
          best_sym_q <= nd_sym_q;
          best_idx_q <= i_q[NIW-1:0];
        end
      end
      hcb_pkg::OP_TAKE_A: begin
        a_w_q   <= best_w_q;
        a_idx_q <= best_idx_q;
      end
      hcb_pkg::OP_STK_NODE: begin
        cur_code_q <= stk_code_q;
        cur_len_q  <= stk_len_q;
      end
      hcb_pkg::OP_EMIT_CODE: begin
        out_kind_o        <= hcb_pkg::KIND_CODE;
        out_symbol_o      <= nd_sym_q;
        out_code_value_o  <= cur_code_q;
        out_code_length_o <= cur_len_q;
        out_frequency_o   <= hcb_pkg::FREQ_W'(cnt_val);
        out_last_o        <= (sp_q == '0);
      end
      hcb_pkg::OP_EMIT_SYM: begin
        out_kind_o        <= hcb_pkg::KIND_SYM;
        out_symbol_o      <= nd_sym_q;
        out_code_value_o  <= '0;
        out_code_length_o <= '0;
        out_frequency_o   <= hcb_pkg::FREQ_W'(cnt_val);
        out_last_o        <= 1'b1;
      end
      hcb_pkg::OP_EMIT_ERR: begin
        out_kind_o        <= hcb_pkg::KIND_ERR;
        out_symbol_o      <= '0;
        out_code_value_o  <= '0;
        out_code_length_o <= '0;
        out_frequency_o   <= '0;
        out_last_o        <= 1'b1;
      end
      default: sym_q <= sym_q;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // Report status to the sequencer
  assign status_o.tree_built   = tree_built_q;
  assign status_o.root_leaf    = root_leaf_q;
  assign status_o.distinct_bad = (distinct_q == '0) ||
                                 (distinct_q > (hcb_pkg::SYM_W + 1)'(MAX_SYMBOLS));
  assign status_o.scan_end     = s_q[hcb_pkg::SYM_W];
  assign status_o.leaf_valid   = cnt_vld_q[s_q[hcb_pkg::SYM_W-1:0]];
  assign status_o.one_left     = (live_cnt_q == LCW'(1));
  assign status_o.pass_end     = (CW'(i_q + CW'(1)) == used_q);
  assign status_o.node_leaf    = nd_leaf_q;
  assign status_o.stack_empty  = (sp_q == '0);
  assign status_o.out_free     = out_free;

  `HCB_ASSERT(a_emit_free, (op == hcb_pkg::OP_EMIT_CODE || op == hcb_pkg::OP_EMIT_SYM || op == hcb_pkg::OP_EMIT_ERR) |-> out_free, "item loaded over a pending result")
  `HCB_ASSERT(a_stack_bound, sp_q <= SPW'(MAX_SYMBOLS), "traversal stack overflow")
  `HCB_ASSERT(a_root_leaf, tree_built_q |-> (root_leaf_q == (distinct_q == (hcb_pkg::SYM_W + 1)'(1))), "root leaf flag disagrees with symbol count")
  `HCB_ASSERT(a_live_bound, live_cnt_q <= LCW'(MAX_SYMBOLS), "live node count out of range")

endmodule

// ===== rtl/core/huffman_code_builder_decoder_core.sv =====
// A text item is read, incremented and written back; a decode bit descends one tree level,
// and a found symbol waits for the output register. Build: a 256-step count scan writes
// a leaf per counted symbol, then each merge scans the node store twice; code emission pops
// the traversal stack once per tree node and waits for the output register.
// One item is in work at a time; the output register holds one result.
// Reset: asynchronous, active low; counts, tree and output clear at once.
module huffman_code_builder_decoder_core #(
  parameter int unsigned MAX_SYMBOLS = 64,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  in_cmd_i,
  input  logic [hcb_pkg::SYM_W-1:0]   in_symbol_i,
  input  logic                        in_code_bit_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  out_kind_o,
  output logic [hcb_pkg::SYM_W-1:0]   out_symbol_o,
  output logic [hcb_pkg::CODE_W-1:0]  out_code_value_o,
  output logic [hcb_pkg::LEN_W-1:0]   out_code_length_o,
  output logic [hcb_pkg::FREQ_W-1:0]  out_frequency_o,
  output logic                        out_last_o
);

  hcb_pkg::hcb_cmd_t    cmd;
  hcb_pkg::hcb_status_t status;

  hcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_cmd_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hcb_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .in_symbol_i       (in_symbol_i),
    .in_code_bit_i     (in_code_bit_i),
    .out_stall_i       (out_stall_i),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_kind_o        (out_kind_o),
    .out_symbol_o      (out_symbol_o),
    .out_code_value_o  (out_code_value_o),
    .out_code_length_o (out_code_length_o),
    .out_frequency_o   (out_frequency_o),
    .out_last_o        (out_last_o)
  );

endmodule
